### src/mcgt_pkg.sv
// shared types and codes for the multicast group member table
package mcgt_pkg;

  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int MCNT_W = 7;   // holds a member count up to 127

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;
  localparam logic [1:0] FN_CLEAR  = 2'd3;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_FULL      = 3'd1;
  localparam logic [2:0] STS_NO_GROUP  = 3'd2;
  localparam logic [2:0] STS_NO_MEMBER = 3'd3;
  localparam logic [2:0] STS_LIST_FULL = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [MAC_W-1:0]  grp;
    logic [MAC_W-1:0]  mem;
    logic              has;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] limit;
  } op_t;

  // token walking down the row of slots
  typedef struct packed {
    logic act;
    logic m;   // a match was already claimed upstream
    logic v;   // a vacancy was already claimed upstream
  } tok_t;

  typedef struct packed {
    logic go;
    logic clear;
    logic refresh;
    logic add;
    logic del_member;
    logic drop;
    logic init;
  } cmd_t;

  typedef struct packed {
    logic              hit;
    logic              full;
    logic [MCNT_W-1:0] cnt;
    logic              occ;
  } rep_t;

endpackage

### src/mcgt_in_if.sv
// input item channel
interface mcgt_in_if;
  import mcgt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [MAC_W-1:0]  group_addr;
  logic [MAC_W-1:0]  member_addr;
  logic              has_member;
  logic [TIME_W-1:0] now_time;
  modport source(output valid, func, group_addr, member_addr, has_member, now_time,
                 input ready);
  modport sink(input valid, func, group_addr, member_addr, has_member, now_time,
               output ready);
endinterface

### src/mcgt_out_if.sv
// result item channel
interface mcgt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       found;
  logic [4:0] member_count;
  logic [5:0] group_count;
  modport source(output valid, status, found, member_count, group_count, input ready);
  modport sink(input valid, status, found, member_count, group_count, output ready);
endinterface

### src/mcgt_cfg_if.sv
// configuration write channel
interface mcgt_cfg_if;
  import mcgt_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### src/mcgt_cell.sv
// one group slot with its member list
module mcgt_cell #(
  parameter int MEMBERS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mcgt_pkg::op_t  op,
  input  logic           start,
  input  mcgt_pkg::cmd_t cmd,
  input  mcgt_pkg::tok_t tok_in,
  output mcgt_pkg::tok_t tok_out,
  output mcgt_pkg::rep_t rep,
  output logic           sel_o,
  output logic           vac_o
);
  import mcgt_pkg::*;

  logic                v_r, v_nxt;
  logic                sel_r, sel_nxt;
  logic                vac_r, vac_nxt;
  logic [MEMBERS-1:0]  mv_r, mv_nxt;
  tok_t                tok_r, tok_nxt;
  logic [MAC_W-1:0]    grp_r;
  logic [TIME_W-1:0]   seen_r;
  logic [MAC_W-1:0]    mm_r [MEMBERS];

  logic                match, vacant, mhit, mfull;
  logic [TIME_W-1:0]   age;
  logic [MEMBERS-1:0]  hitv, ffree, mm_we, mv_init;
  logic                do_add, do_init, do_refresh;

  always_comb begin
    match  = v_r && (grp_r == op.grp);
    age    = op.now - seen_r;
    vacant = !v_r || (age > op.limit);
    for (int j = 0; j < MEMBERS; j++) begin
      hitv[j] = mv_r[j] && (mm_r[j] == op.mem);
    end
    mhit  = |hitv;
    mfull = &mv_r;
    // lowest empty member entry
    ffree = ~mv_r & (mv_r + 1'b1);
    mv_init    = '0;
    mv_init[0] = op.has;
    do_add     = cmd.go && sel_r && cmd.add;
    do_init    = cmd.go && vac_r && cmd.init;
    do_refresh = cmd.go && sel_r && cmd.refresh;
    mm_we = do_add ? ffree : '0;
    if (do_init) begin
      mm_we[0] = 1'b1;
    end
  end

  always_comb begin
    v_nxt   = v_r;
    mv_nxt  = mv_r;
    sel_nxt = sel_r;
    vac_nxt = vac_r;
    if (start) begin
      sel_nxt = 1'b0;
      vac_nxt = 1'b0;
    end
    if (tok_in.act) begin
      if (match && !tok_in.m) sel_nxt = 1'b1;
      if (vacant && !tok_in.v) vac_nxt = 1'b1;
    end
    tok_nxt.act = tok_in.act;
    tok_nxt.m   = tok_in.m | match;
    tok_nxt.v   = tok_in.v | vacant;
    if (cmd.go) begin
      if (cmd.clear) begin
        v_nxt  = 1'b0;
        mv_nxt = '0;
      end
      if (sel_r) begin
        if (cmd.add) mv_nxt = mv_r | ffree;
        if (cmd.del_member) mv_nxt = mv_r & ~hitv;
        if (cmd.drop) begin
          v_nxt  = 1'b0;
          mv_nxt = '0;
        end
      end
      if (do_init) begin
        v_nxt  = 1'b1;
        mv_nxt = mv_init;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      mv_r  <= '0;
      sel_r <= 1'b0;
      vac_r <= 1'b0;
      tok_r <= '0;
    end else begin
      v_r   <= v_nxt;
      mv_r  <= mv_nxt;
      sel_r <= sel_nxt;
      vac_r <= vac_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_init) begin
      grp_r  <= op.grp;
      seen_r <= op.now;
    end else if (do_refresh) begin
      seen_r <= op.now;
    end
    for (int j = 0; j < MEMBERS; j++) begin
      if (mm_we[j]) mm_r[j] <= op.mem;
    end
  end

  assign tok_out  = tok_r;
  assign rep.hit  = sel_r & mhit;
  assign rep.full = sel_r & mfull;
  assign rep.cnt  = sel_r ? MCNT_W'($countones(mv_r)) : '0;
  assign rep.occ  = vac_r & v_r;
  assign sel_o    = sel_r;
  assign vac_o    = vac_r;

endmodule

### src/mcgt_ctrl.sv
// sequencer: latches an item, runs the slot scan, applies the command, holds the result
module mcgt_ctrl #(
  parameter int GROUP_SLOTS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  mcgt_in_if.sink         in_ch,
  mcgt_out_if.source      out_ch,
  mcgt_cfg_if.sink        cfg_ch,
  output mcgt_pkg::op_t   op,
  output logic            start,
  input  mcgt_pkg::tok_t  tok_last,
  input  mcgt_pkg::rep_t  rep,
  output mcgt_pkg::cmd_t  cmd
);
  import mcgt_pkg::*;

  localparam int GC_W = $clog2(GROUP_SLOTS + 1);

  state_t             state_r, state_nxt;
  op_t                op_r;
  logic [TIME_W-1:0]  limit_r;
  logic [GC_W-1:0]    gcnt_r, gcnt_nxt;
  logic               found_r, vac_r, found_nxt, vac_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_st_r;
  logic               out_found_r;
  logic [4:0]         out_mc_r;
  logic [5:0]         out_gc_r;

  logic               accept, full;
  logic [2:0]         st;
  logic [MCNT_W-1:0]  mc, after;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign start        = (state_r == S_START);
  assign full         = gcnt_r >= GC_W'(GROUP_SLOTS);
  assign after        = rep.cnt - MCNT_W'(rep.hit);

  always_comb begin
    op       = op_r;
    op.limit = limit_r;
  end

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    vac_nxt   = vac_r;
    cmd       = '0;
    st        = STS_OK;
    mc        = '0;
    gcnt_nxt  = gcnt_r;
    cmd.go    = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
    case (op_r.func)
      FN_INSERT: begin
        if (full) begin
          st = STS_FULL;
          mc = rep.cnt;
        end else if (found_r) begin
          cmd.refresh = 1'b1;
          mc = rep.cnt;
          if (!op_r.has) begin
            st = STS_NO_MEMBER;
          end else if (rep.hit) begin
            st = STS_OK;
          end else if (rep.full) begin
            st = STS_LIST_FULL;
          end else begin
            cmd.add = 1'b1;
            mc = rep.cnt + 1'b1;
          end
        end else if (vac_r) begin
          cmd.init = 1'b1;
          mc = MCNT_W'(op_r.has);
          // reclaiming an aged slot leaves the count as it was
          if (!rep.occ) gcnt_nxt = gcnt_r + 1'b1;
        end else begin
          st = STS_FULL;
        end
      end
      FN_DELETE: begin
        if (!found_r) begin
          st = STS_NO_GROUP;
        end else if (!op_r.has || after == '0) begin
          cmd.drop = 1'b1;
          gcnt_nxt = gcnt_r - 1'b1;
        end else if (rep.hit) begin
          cmd.del_member = 1'b1;
          mc = after;
        end else begin
          st = STS_NO_MEMBER;
          mc = rep.cnt;
        end
      end
      FN_LOOKUP: begin
        if (found_r) begin
          cmd.refresh = 1'b1;
          mc = rep.cnt;
        end else begin
          st = STS_NO_GROUP;
        end
      end
      default: begin
        cmd.clear = 1'b1;
        gcnt_nxt  = '0;
      end
    endcase
    if (!cmd.go) gcnt_nxt = gcnt_r;

    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_START;
      S_START: state_nxt = S_SCAN;
      S_SCAN: begin
        if (tok_last.act) begin
          found_nxt = tok_last.m;
          vac_nxt   = tok_last.v;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC:  if (cmd.go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gcnt_r      <= '0;
      found_r     <= 1'b0;
      vac_r       <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= TIME_W'(30000);
    end else begin
      state_r     <= state_nxt;
      gcnt_r      <= gcnt_nxt;
      found_r     <= found_nxt;
      vac_r       <= vac_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) limit_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r.func  <= in_ch.func;
      op_r.grp   <= in_ch.group_addr;
      op_r.mem   <= in_ch.member_addr;
      op_r.has   <= in_ch.has_member;
      op_r.now   <= in_ch.now_time;
      op_r.limit <= '0;
    end
    if (cmd.go) begin
      out_st_r    <= st;
      out_found_r <= found_r;
      out_mc_r    <= mc[4:0];
      out_gc_r    <= 6'(gcnt_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.member_count = out_mc_r;
  assign out_ch.group_count  = out_gc_r;

endmodule

### src/multicast_group_member_table_unit.sv
// top level: row of group slot cells behind the operation sequencer
// A token walks the row of slot cells one cell per cycle to find the matching group and the
// lowest free or aged slot, then the EXEC state applies the operation once the output can
// take the result. The next item can be taken in the cycle after that. A new item is taken
// while the previous result still waits at the output. age_limit is written through the cfg
// channel; the user writes it only at idle time, the block itself leaves this unenforced.
module multicast_group_member_table_unit #(
  parameter int GROUP_SLOTS       = 32,
  parameter int MEMBERS_PER_GROUP = 16
) (
  input logic        clk,
  input logic        rst_n,
  mcgt_in_if.sink    in_ch,
  mcgt_out_if.source out_ch,
  mcgt_cfg_if.sink   cfg_ch
);
  import mcgt_pkg::*;

  op_t                    op;
  cmd_t                   cmd;
  logic                   start;
  tok_t                   tok [GROUP_SLOTS+1];
  rep_t                   rep_cell [GROUP_SLOTS];
  rep_t                   rep;
  logic [GROUP_SLOTS-1:0] sel_vec, vac_vec, tok_vec;

  assign tok[0] = '{act: start, m: 1'b0, v: 1'b0};

  for (genvar i = 0; i < GROUP_SLOTS; i++) begin : g_cell
    mcgt_cell #(.MEMBERS(MEMBERS_PER_GROUP)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .op     (op),
      .start  (start),
      .cmd    (cmd),
      .tok_in (tok[i]),
      .tok_out(tok[i+1]),
      .rep    (rep_cell[i]),
      .sel_o  (sel_vec[i]),
      .vac_o  (vac_vec[i])
    );
    assign tok_vec[i] = tok[i+1].act;
  end

  // reports are zero outside the claimed match and vacancy cells
  always_comb begin
    rep = '0;
    for (int i = 0; i < GROUP_SLOTS; i++) begin
      rep = rep | rep_cell[i];
    end
  end

  mcgt_ctrl #(.GROUP_SLOTS(GROUP_SLOTS)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .op      (op),
    .start   (start),
    .tok_last(tok[GROUP_SLOTS]),
    .rep     (rep),
    .cmd     (cmd)
  );

  a_one_match: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sel_vec))
    else $error("more than one slot claimed as match");
  a_one_vacancy: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vac_vec))
    else $error("more than one slot claimed as vacancy");
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_vec))
    else $error("more than one token in the slot row");

endmodule
